[design/neighbour_reception_ratio_unit_macros.svh]
// Assertion macros shared by the checker of the neighbour reception ratio unit.
`ifndef NEIGHBOUR_RECEPTION_RATIO_UNIT_MACROS_SVH
`define NEIGHBOUR_RECEPTION_RATIO_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NRR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neighbour reception ratio check failed");

// Next-cycle implication, checked outside reset.
`define NRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neighbour reception ratio check failed");

`endif

[design/nrr_pkg.sv]
// Shared constants and types of the neighbour reception ratio unit.
package nrr_pkg;

    localparam int NODE_COUNT     = 64;
    localparam int NODE_IDX_BITS  = $clog2(NODE_COUNT);
    localparam int NODE_ID_BITS   = 6;
    localparam int SEQ_BITS       = 16;
    localparam int SEQ_IN_BITS    = 16;
    localparam int COUNT_BITS     = 16;
    localparam int STRENGTH_BITS  = 16;
    localparam int RATIO_SCALE    = 25600;
    localparam int SCALE_BITS     = $clog2(RATIO_SCALE + 1);
    localparam int NUM_BITS       = COUNT_BITS + SCALE_BITS;
    localparam int DIV_CNT_BITS   = $clog2(NUM_BITS);

    // Queue depth must be a power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0]    COUNT_MAX    = '1;
    localparam logic [STRENGTH_BITS-1:0] STRENGTH_MAX = '1;

    localparam logic ACTION_BEACON = 1'b0;
    localparam logic ACTION_QUERY  = 1'b1;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic                     is_query;
        logic                     known;
        logic                     node_zero;
        logic [NODE_IDX_BITS-1:0] idx;
        logic [SEQ_BITS-1:0]      seq;
    } item_t;

endpackage

[design/nrr_front.sv]
// Front part: accepts commands, classifies them and queues them for the back part.
module nrr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                action,
    input  logic [nrr_pkg::NODE_ID_BITS-1:0]    node_id,
    input  logic [nrr_pkg::SEQ_IN_BITS-1:0]     seq_num,
    input  logic                                pop,
    output logic                                busy,
    output logic                                q_valid,
    output nrr_pkg::item_t                      q_item
);

    nrr_pkg::item_t                         slot_reg [nrr_pkg::QUEUE_DEPTH];
    logic [nrr_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_reg;
    logic [nrr_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_reg;
    logic [nrr_pkg::QUEUE_PTR_BITS:0]       fill_reg;
    logic [nrr_pkg::QUEUE_PTR_BITS:0]       fill_next;
    nrr_pkg::item_t                         new_item;
    logic                                   push;
    logic                                   pop_ok;

    // Classify the incoming command.
    always_comb
    begin
        new_item.is_query  = (action == nrr_pkg::ACTION_QUERY);
        new_item.known     = (32'(node_id) < nrr_pkg::NODE_COUNT);
        new_item.node_zero = (node_id == '0);
        new_item.idx       = nrr_pkg::NODE_IDX_BITS'(node_id);
        new_item.seq       = nrr_pkg::SEQ_BITS'(seq_num);
    end

    assign busy    = (fill_reg == (nrr_pkg::QUEUE_PTR_BITS + 1)'(nrr_pkg::QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (fill_reg != '0);
    assign pop_ok  = pop && q_valid;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop_ok)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop_ok && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

[design/nrr_back.sv]
// Back part: updates the node count table and computes the ratio with a bit-serial divider.
module nrr_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  nrr_pkg::item_t                      q_item,
    output logic                                pop,
    output logic                                done,
    output logic [nrr_pkg::STRENGTH_BITS-1:0]   strength,
    output logic [nrr_pkg::COUNT_BITS-1:0]      reception_count
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    logic [nrr_pkg::COUNT_BITS-1:0]     mem [nrr_pkg::NODE_COUNT];
    logic [nrr_pkg::NODE_COUNT-1:0]     valid_reg;
    logic [nrr_pkg::COUNT_BITS-1:0]     rd_data_reg;
    logic                               rd_valid_reg;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    nrr_pkg::item_t                     item_reg;
    logic [nrr_pkg::SEQ_BITS-1:0]       highest_reg;
    logic [nrr_pkg::COUNT_BITS-1:0]     count_reg;
    logic [nrr_pkg::NUM_BITS-1:0]       num_reg;
    logic [nrr_pkg::SEQ_BITS-1:0]       rem_reg;
    logic [nrr_pkg::DIV_CNT_BITS-1:0]   bit_cnt_reg;
    logic                               done_reg;
    logic [nrr_pkg::STRENGTH_BITS-1:0]  strength_reg;
    logic [nrr_pkg::COUNT_BITS-1:0]     rcount_reg;

    logic [nrr_pkg::COUNT_BITS-1:0]     cur_count;
    logic [nrr_pkg::COUNT_BITS-1:0]     new_count;
    logic                               mem_we;
    logic                               force_zero;
    logic [nrr_pkg::SEQ_BITS:0]         trial;
    logic                               fits;
    logic                               over;

    assign pop = (state_reg == ST_IDLE) && q_valid;

    // Count of the node as read; unwritten entries and unknown nodes read zero.
    always_comb
    begin
        cur_count = (rd_valid_reg && item_reg.known) ? rd_data_reg : '0;
        new_count = cur_count;
        mem_we    = 1'b0;
        if (!item_reg.is_query && item_reg.known && (cur_count != nrr_pkg::COUNT_MAX))
        begin
            new_count = cur_count + 1'b1;
            mem_we    = (state_reg == ST_READ);
        end
    end

    assign force_zero = item_reg.node_zero || !item_reg.known || (highest_reg == '0);
    assign trial      = {rem_reg, num_reg[nrr_pkg::NUM_BITS-1]};
    assign fits       = (trial >= {1'b0, highest_reg});
    assign over       = (num_reg[nrr_pkg::NUM_BITS-1:nrr_pkg::STRENGTH_BITS] != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = force_zero ? ST_IDLE : ST_DIV;
            ST_DIV:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Count table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[item_reg.idx] <= new_count;
        end
        rd_data_reg <= mem[q_item.idx];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_READ)
        begin
            count_reg <= new_count;
        end
        if (state_reg == ST_MUL)
        begin
            num_reg     <= nrr_pkg::NUM_BITS'(count_reg) *
                           nrr_pkg::NUM_BITS'(nrr_pkg::RATIO_SCALE);
            rem_reg     <= '0;
            bit_cnt_reg <= nrr_pkg::DIV_CNT_BITS'(nrr_pkg::NUM_BITS - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg     <= fits ? nrr_pkg::SEQ_BITS'(trial - {1'b0, highest_reg})
                                : nrr_pkg::SEQ_BITS'(trial);
            num_reg     <= {num_reg[nrr_pkg::NUM_BITS-2:0], fits};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
        if ((state_reg == ST_MUL) && force_zero)
        begin
            strength_reg <= '0;
            rcount_reg   <= count_reg;
        end
        else if (state_reg == ST_SAT)
        begin
            strength_reg <= over ? nrr_pkg::STRENGTH_MAX
                                 : num_reg[nrr_pkg::STRENGTH_BITS-1:0];
            rcount_reg   <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            highest_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= valid_reg[q_item.idx];
            if (mem_we)
            begin
                valid_reg[item_reg.idx] <= 1'b1;
            end
            if ((state_reg == ST_READ) && !item_reg.is_query && (item_reg.seq > highest_reg))
            begin
                highest_reg <= item_reg.seq;
            end
            done_reg <= ((state_reg == ST_MUL) && force_zero) || (state_reg == ST_SAT);
        end
    end

    assign done            = done_reg;
    assign strength        = strength_reg;
    assign reception_count = rcount_reg;

endmodule

[design/neighbour_reception_ratio_unit.sv]
// Top level of the neighbour reception ratio unit.
//
//  Channel   Handshake          Payload ports
//  --------  -----------------  -------------------------------
//  command   start / busy       action, node_id, seq_num
//  result    done (one cycle)   strength, reception_count
//
// A command transfer completes at a rising edge with start high and busy low.
// In the back part a command whose ratio is computed passes through these steps:
// a read of the count table, its update, a multiply, 31 steps of the bit-serial
// divider and a saturation. A command whose ratio is forced to zero skips the last two.
// The front queue holds two commands; busy is high only while it is full.
// Reset clears the count table at once through per-node valid bits; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle with done high.
module neighbour_reception_ratio_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [nrr_pkg::NODE_ID_BITS-1:0]    node_id,
    input  logic [nrr_pkg::SEQ_IN_BITS-1:0]     seq_num,
    output logic                                done,
    output logic [nrr_pkg::STRENGTH_BITS-1:0]   strength,
    output logic [nrr_pkg::COUNT_BITS-1:0]      reception_count
);

    // Queue interface between the front and the back.
    logic           q_valid;
    logic           pop;
    nrr_pkg::item_t q_item;

    // The front classifies each command (known node, node zero, beacon or query)
    // and holds it until the back part is free.
    nrr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .action  (action),
        .node_id (node_id),
        .seq_num (seq_num),
        .pop     (pop),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // The back owns the count table and the highest sequence number, and runs
    // the divide 25600 * count / highest for one command at a time, in order.
    nrr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .pop             (pop),
        .done            (done),
        .strength        (strength),
        .reception_count (reception_count)
    );

endmodule

[design/nrr_checker.sv]
// Port-level checker of the neighbour reception ratio unit and its bind.
`include "neighbour_reception_ratio_unit_macros.svh"

module nrr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [nrr_pkg::STRENGTH_BITS-1:0]   strength,
    input  logic [nrr_pkg::COUNT_BITS-1:0]      reception_count
);

    // A nonzero ratio needs at least one counted beacon.
    `NRR_ASSERT_NOW(a_strength_needs_count, clk, rst_n, done, (strength == '0) || (reception_count != '0))

    // Results never come in adjacent cycles.
    `NRR_ASSERT_NEXT(a_done_spaced, clk, rst_n, done, !done)

    // A result stays on the ports after its strobe.
    `NRR_ASSERT_NEXT(a_result_held, clk, rst_n, done, $stable(strength) && $stable(reception_count))

    // The queue can only fill up through a transfer, so busy rises only after start.
    `NRR_ASSERT_NEXT(a_busy_needs_start, clk, rst_n, !busy && !start, !busy)

endmodule

bind neighbour_reception_ratio_unit nrr_checker u_nrr_checker (.*);

[dv/neighbour_reception_ratio_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the neighbour reception ratio unit: directed and random traffic.
module neighbour_reception_ratio_unit_test;

    // One expected result, with the command that caused it kept for reporting.
    typedef struct {
        logic [nrr_pkg::STRENGTH_BITS-1:0] strength;
        logic [nrr_pkg::COUNT_BITS-1:0]    reception_count;
        logic                              action;
        logic [nrr_pkg::NODE_ID_BITS-1:0]  node_id;
    } ratio_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              action;
    logic [nrr_pkg::NODE_ID_BITS-1:0]  node_id;
    logic [nrr_pkg::SEQ_IN_BITS-1:0]   seq_num;
    logic                              done;
    logic [nrr_pkg::STRENGTH_BITS-1:0] strength;
    logic [nrr_pkg::COUNT_BITS-1:0]    reception_count;

    neighbour_reception_ratio_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .node_id         (node_id),
        .seq_num         (seq_num),
        .done            (done),
        .strength        (strength),
        .reception_count (reception_count)
    );

    // Shadow copy of the block's state: one beacon counter per node and the
    // highest sequence number seen so far.
    logic [nrr_pkg::COUNT_BITS-1:0] node_beacons [nrr_pkg::NODE_COUNT];
    logic [nrr_pkg::SEQ_BITS-1:0]   newest_seq;

    // Results still owed by the block, oldest first.
    ratio_result_t expected_ratios [$];

    int  mismatch_count;
    int  results_checked;
    int  beacons_sent;
    int  queries_sent;
    int  saturated_ratios;
    bit  gaps_enabled;

    // The clock runs with an 8 ns period.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Works out the result of one command and updates the shadow state the way
    // the block does. A beacon first raises the highest sequence and bumps its
    // node's counter, which sticks at its maximum instead of wrapping. The ratio
    // is then 25600 * count / highest sequence, truncated and clipped to the
    // strength width. It is forced to zero for node zero, for a node outside
    // the table, and while no nonzero sequence has been seen.
    function automatic ratio_result_t predict_ratio(
        input logic                             act,
        input logic [nrr_pkg::NODE_ID_BITS-1:0] nid,
        input logic [nrr_pkg::SEQ_IN_BITS-1:0]  sq
    );
        ratio_result_t                r;
        logic [nrr_pkg::SEQ_BITS-1:0] used_seq;
        bit                           known;
        longint unsigned              quotient;
        used_seq = sq[nrr_pkg::SEQ_BITS-1:0];
        known    = (nid < nrr_pkg::NODE_COUNT);
        if (act == nrr_pkg::ACTION_BEACON)
        begin
            if (used_seq > newest_seq)
                newest_seq = used_seq;
            if (known && node_beacons[nid] != nrr_pkg::COUNT_MAX)
                node_beacons[nid] = node_beacons[nid] + 1'b1;
        end
        r.action          = act;
        r.node_id         = nid;
        r.reception_count = known ? node_beacons[nid] : '0;
        if (!known || nid == 0 || newest_seq == 0)
            r.strength = '0;
        else
        begin
            quotient = 64'(node_beacons[nid]);
            quotient = (quotient * nrr_pkg::RATIO_SCALE) / newest_seq;
            r.strength = (quotient > nrr_pkg::STRENGTH_MAX) ? nrr_pkg::STRENGTH_MAX
                                                            : quotient[nrr_pkg::STRENGTH_BITS-1:0];
        end
        return r;
    endfunction

    // Sends one command. The task is entered and left at a rising edge. When
    // gaps are enabled it may first hold start low for a random stretch, short
    // most of the time and sometimes long enough for the block to drain, so that
    // the next transfer lands on every phase of the block's work. Busy is
    // sampled on the falling edge, where it is stable, and the transfer
    // completes at the next rising edge at which busy was low.
    task automatic send_item(
        input logic                             act,
        input logic [nrr_pkg::NODE_ID_BITS-1:0] nid,
        input logic [nrr_pkg::SEQ_IN_BITS-1:0]  sq
    );
        int            gap;
        bit            ready;
        ratio_result_t r;
        gap = 0;
        if (gaps_enabled && $urandom_range(99) < 27)
            gap = ($urandom_range(3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        action  <= act;
        node_id <= nid;
        seq_num <= sq;
        do
        begin
            @(negedge clk);
            ready = !busy;
            @(posedge clk);
        end
        while (!ready);
        r = predict_ratio(act, nid, sq);
        expected_ratios.push_back(r);
        if (act == nrr_pkg::ACTION_BEACON)
            beacons_sent++;
        else
            queries_sent++;
        if (r.strength == nrr_pkg::STRENGTH_MAX)
            saturated_ratios++;
    endtask

    // Before any nonzero sequence is seen every ratio reads zero, even for a
    // node that already has beacons counted. Queries ignore their sequence field.
    task automatic test_empty_state();
        send_item(nrr_pkg::ACTION_QUERY,  6'd5,  16'hFFFF);
        send_item(nrr_pkg::ACTION_QUERY,  6'd0,  16'h0000);
        send_item(nrr_pkg::ACTION_BEACON, 6'd7,  16'h0000);
        send_item(nrr_pkg::ACTION_BEACON, 6'd0,  16'h0000);
        send_item(nrr_pkg::ACTION_QUERY,  6'd63, 16'hA5A5);
        send_item(nrr_pkg::ACTION_QUERY,  6'd7,  16'h5A5A);
    endtask

    // With the highest sequence at one, three beacons take a node past 256
    // percent, so its strength clips. Node zero keeps counting but reads zero.
    task automatic test_ratio_saturation();
        send_item(nrr_pkg::ACTION_BEACON, 6'd5, 16'd1);
        send_item(nrr_pkg::ACTION_BEACON, 6'd5, 16'd1);
        send_item(nrr_pkg::ACTION_BEACON, 6'd5, 16'd1);
        send_item(nrr_pkg::ACTION_BEACON, 6'd7, 16'd1);
        send_item(nrr_pkg::ACTION_BEACON, 6'd0, 16'd1);
        send_item(nrr_pkg::ACTION_QUERY,  6'd5, 16'd0);
    endtask

    // Random traffic shaped like a beacon network. Most commands are beacons
    // from random neighbours that carry the current round's sequence, with the
    // round moving on now and then and sometimes skipping numbers as if
    // beacons were lost. One favourite node transmits far more often than the
    // others, which drives its ratio into saturation. The rest is queries with
    // junk in the sequence field, stale out-of-order beacons, beacons from the
    // edge node ids, and near the end beacons with arbitrary sequence numbers.
    // A stretch in the middle runs with no gaps at all.
    task automatic test_random_traffic(input int item_total);
        int                               sent;
        int                               pick;
        logic [nrr_pkg::SEQ_IN_BITS-1:0]  round_seq;
        logic [nrr_pkg::NODE_ID_BITS-1:0] favourite;
        logic [nrr_pkg::NODE_ID_BITS-1:0] nid;
        sent      = 0;
        round_seq = newest_seq + 1'b1;
        favourite = nrr_pkg::NODE_ID_BITS'($urandom_range(1, nrr_pkg::NODE_COUNT - 1));
        while (sent < item_total)
        begin
            gaps_enabled = !(sent >= (item_total * 2) / 5 && sent < (item_total * 3) / 5);
            pick = $urandom_range(99);
            nid  = nrr_pkg::NODE_ID_BITS'($urandom_range(1, nrr_pkg::NODE_COUNT - 1));
            if (pick < 40)
                send_item(nrr_pkg::ACTION_BEACON, nid, round_seq);
            else if (pick < 65)
                send_item(nrr_pkg::ACTION_BEACON, favourite, round_seq);
            else if (pick < 82)
                send_item(nrr_pkg::ACTION_QUERY,
                          nrr_pkg::NODE_ID_BITS'($urandom_range(nrr_pkg::NODE_COUNT - 1)),
                          nrr_pkg::SEQ_IN_BITS'($urandom));
            else if (pick < 88)
                send_item(nrr_pkg::ACTION_BEACON, nid,
                          nrr_pkg::SEQ_IN_BITS'($urandom_range(0, round_seq)));
            else if (pick < 93)
                send_item(nrr_pkg::ACTION_BEACON, ($urandom_range(1) == 0) ? 6'd0 : 6'd63,
                          round_seq);
            else if (sent >= (item_total * 9) / 10)
                send_item(nrr_pkg::ACTION_BEACON,
                          nrr_pkg::NODE_ID_BITS'($urandom_range(nrr_pkg::NODE_COUNT - 1)),
                          nrr_pkg::SEQ_IN_BITS'($urandom));
            else
                send_item(nrr_pkg::ACTION_QUERY, favourite, nrr_pkg::SEQ_IN_BITS'($urandom));
            if ($urandom_range(11) == 0)
                round_seq = round_seq + nrr_pkg::SEQ_IN_BITS'($urandom_range(1, 3));
            sent++;
        end
        gaps_enabled = 1'b1;
    endtask

    // The largest sequence number, a stale one below it that must not lower
    // the highest, a beacon with sequence zero, and the edge node ids.
    task automatic test_sequence_extremes();
        send_item(nrr_pkg::ACTION_BEACON, 6'd63, 16'hFFFF);
        send_item(nrr_pkg::ACTION_QUERY,  6'd63, 16'h0000);
        send_item(nrr_pkg::ACTION_QUERY,  6'd5,  16'hFFFF);
        send_item(nrr_pkg::ACTION_BEACON, 6'd1,  16'h8000);
        send_item(nrr_pkg::ACTION_BEACON, 6'd63, 16'h0000);
        send_item(nrr_pkg::ACTION_QUERY,  6'd0,  16'h0000);
    endtask

    // Every result is compared with the oldest expectation. The block cannot
    // be held off, so a result is taken at the rising edge that ends the cycle
    // in which done is high; the values read here are the ones from before the
    // edge.
    always @(posedge clk)
    begin : check_results
        ratio_result_t want;
        if (rst_n && done)
        begin
            if (expected_ratios.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no transfer pending: strength %0d count %0d",
                         $time, strength, reception_count);
            end
            else
            begin
                want = expected_ratios.pop_front();
                results_checked++;
                if (strength !== want.strength)
                begin
                    mismatch_count++;
                    $display("%0t: strength mismatch (action %0d node %0d): expected %0d, actual %0d",
                             $time, want.action, want.node_id, want.strength, strength);
                end
                if (reception_count !== want.reception_count)
                begin
                    mismatch_count++;
                    $display("%0t: count mismatch (action %0d node %0d): expected %0d, actual %0d",
                             $time, want.action, want.node_id, want.reception_count,
                             reception_count);
                end
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then drain.
    initial
    begin : run_tests
        int drain_cycles;
        rst_n   = 1'b0;
        start   = 1'b0;
        action  = nrr_pkg::ACTION_BEACON;
        node_id = '0;
        seq_num = '0;
        for (int i = 0; i < nrr_pkg::NODE_COUNT; i++)
            node_beacons[i] = '0;
        newest_seq       = '0;
        mismatch_count   = 0;
        results_checked  = 0;
        beacons_sent     = 0;
        queries_sent     = 0;
        saturated_ratios = 0;
        gaps_enabled     = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_state();
        test_ratio_saturation();
        test_random_traffic(1200);
        test_sequence_extremes();
        start <= 1'b0;

        // Wait for the block to return every owed result, then give it time
        // to show any stray one. A result that never comes is a failure.
        drain_cycles = 0;
        while (expected_ratios.size() != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (60) @(posedge clk);
        if (expected_ratios.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_ratios.size());
            mismatch_count += expected_ratios.size();
        end

        $display("Covered %0d beacons and %0d queries, %0d results checked.",
                 beacons_sent, queries_sent, results_checked);
        $display("That took in %0d clipped ratios, an empty start and a stretch with no idling.",
                 saturated_ratios);
        if (mismatch_count == 0)
            $display("neighbour_reception_ratio_unit_test passed");
        else
            $display("neighbour_reception_ratio_unit_test failed");
        $finish;
    end

    // Safety net against a hung handshake or a lost result.
    initial
    begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_ratios.size());
        $display("neighbour_reception_ratio_unit_test failed");
        $finish;
    end

endmodule
